### hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared widths, defaults and control structs of the logistic score pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

	localparam int FEAT_W       = 16;
	localparam int WEIGHT_W     = 16;
	localparam int NUM_FEAT_MAX = 7;
	localparam int NUM_WEIGHTS  = NUM_FEAT_MAX + 1;
	localparam int WIDX_W       = $clog2(NUM_WEIGHTS);
	localparam int TERM_W       = 32;
	localparam int PAIR_W       = TERM_W + 1;
	localparam int QUAD_W       = TERM_W + 2;
	localparam int SUM_W        = TERM_W + 3;
	localparam int SCORE_W      = 32;
	localparam int PROB_W       = 16;
	localparam int NUM_STAGES   = 6;

	localparam int FEATURES_DEF  = 7;
	localparam int FRAC_BITS_DEF = 8;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [FEAT_W-1:0]   feat_t;

	// stage advance strobes for the multiply and adder tree stages
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
	} dot_ctl_t;

	// stage advance strobes for saturation and sigmoid stages
	typedef struct packed {
		logic adv_s4;
		logic adv_s5;
		logic adv_s6;
	} plan_ctl_t;

endpackage

`default_nettype wire

### hdl/lcs_if.sv
// ----------------------------------------------------------------------------
// lcs_if
// Valid/ready channels for feature vectors and score results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcs_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_1;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_2;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_3;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_4;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_5;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_6;
	logic signed [lcs_pkg::FEAT_W-1:0]   feature_7;

	modport source (output valid, feature_1, feature_2, feature_3, feature_4,
		feature_5, feature_6, feature_7, input ready);
	modport sink (input valid, feature_1, feature_2, feature_3, feature_4,
		feature_5, feature_6, feature_7, output ready);
endinterface

interface lcs_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lcs_pkg::SCORE_W-1:0]  score;
	logic        [lcs_pkg::PROB_W-1:0]   probability;

	modport source (output valid, score, probability, input ready);
	modport sink (input valid, score, probability, output ready);
endinterface

`default_nettype wire

### hdl/logistic_classifier_score.sv
// ----------------------------------------------------------------------------
// logistic_classifier_score
// Logistic regression inference: Q16.16 score and PLAN sigmoid probability.
// ----------------------------------------------------------------------------
// Accepts one vector of seven signed Q8.8 features per clock, unless the
// output channel stalls, and returns the biased dot product with eight
// programmable Q8.8 weights as a saturated Q16.16 score together with its
// sigmoid as an unsigned Q0.16 probability. Throughput is one transaction
// per cycle while result.ready stays high. The pipeline has six register
// stages: the multiplier stage, the two adder tree levels, the final add with
// saturation, and two sigmoid stages. A stage holds its item only while the
// stage after it is occupied and stalled, so back-pressure on the result
// channel fills bubbles before it stalls the input. Weights are written
// through cfg_we/cfg_index/cfg_data and should only be changed while the
// pipeline is empty.
`default_nettype none

module logistic_classifier_score #(
	parameter int FEATURES  = lcs_pkg::FEATURES_DEF,
	parameter int FRAC_BITS = lcs_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [lcs_pkg::WIDX_W-1:0]        cfg_index,
	input  wire [lcs_pkg::WEIGHT_W-1:0]      cfg_data,
	lcs_in_if.sink                           sample,
	lcs_out_if.source                        result
);
	import lcs_pkg::*;

	weight_t                   weight_q [NUM_WEIGHTS];
	feat_t                     feat [NUM_FEAT_MAX];
	logic [NUM_STAGES-1:0]     vld_q;
	logic [NUM_STAGES-1:0]     adv;
	logic signed [QUAD_W-1:0]  quad_s3 [2];
	dot_ctl_t                  dot_ctl;
	plan_ctl_t                 plan_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cfg_we) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// a stage advances when it is empty or the stage after it advances
	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = adv[0];

	assign feat[0] = sample.feature_1;
	assign feat[1] = sample.feature_2;
	assign feat[2] = sample.feature_3;
	assign feat[3] = sample.feature_4;
	assign feat[4] = sample.feature_5;
	assign feat[5] = sample.feature_6;
	assign feat[6] = sample.feature_7;

	assign dot_ctl.adv_s1  = adv[0];
	assign dot_ctl.adv_s2  = adv[1];
	assign dot_ctl.adv_s3  = adv[2];
	assign plan_ctl.adv_s4 = adv[3];
	assign plan_ctl.adv_s5 = adv[4];
	assign plan_ctl.adv_s6 = adv[5];

	lcs_dot #(
		.FEATURES  (FEATURES),
		.FRAC_BITS (FRAC_BITS)
	) u_dot (
		.clk     (clk),
		.ctl     (dot_ctl),
		.weight  (weight_q),
		.feat    (feat),
		.quad_s3 (quad_s3)
	);

	lcs_plan #(
		.FRAC_BITS (FRAC_BITS)
	) u_plan (
		.clk      (clk),
		.ctl      (plan_ctl),
		.quad_s3  (quad_s3),
		.score_s6 (result.score),
		.prob_s6  (result.probability)
	);

	assign result.valid = vld_q[NUM_STAGES-1];

	// an empty pipeline with nothing entering produces no result next cycle
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '0) && !sample.valid |=> !result.valid)
		else $error("result appeared from an empty pipeline");

	// a full pipeline blocked at the output must refuse new input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !result.ready |-> !sample.ready)
		else $error("input accepted while pipeline full and stalled");

	// sigmoid mirror: negative scores stay at or below one half
	a_neg_half: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.score[SCORE_W-1] |-> result.probability <= 16'd32768)
		else $error("negative score gave probability above one half");

	a_pos_half: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.score[SCORE_W-1] |-> result.probability >= 16'd32768)
		else $error("non-negative score gave probability below one half");

endmodule

`default_nettype wire

### hdl/lcs_dot.sv
// ----------------------------------------------------------------------------
// lcs_dot
// Weight by feature products and a registered two-level adder tree.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_dot #(
	parameter int FEATURES  = lcs_pkg::FEATURES_DEF,
	parameter int FRAC_BITS = lcs_pkg::FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  lcs_pkg::dot_ctl_t                     ctl,
	input  lcs_pkg::weight_t                      weight [lcs_pkg::NUM_WEIGHTS],
	input  lcs_pkg::feat_t                        feat   [lcs_pkg::NUM_FEAT_MAX],
	output logic signed [lcs_pkg::QUAD_W-1:0]     quad_s3 [2]
);
	import lcs_pkg::*;

	logic signed [TERM_W-1:0] term_s1 [NUM_WEIGHTS];
	logic signed [PAIR_W-1:0] pair_s2 [NUM_WEIGHTS/2];

	// stage 1: bias scaled to the product format, one multiplier per feature
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			term_s1[0] <= TERM_W'(weight[0]) <<< FRAC_BITS;
			for (int i = 1; i < NUM_WEIGHTS; i++) begin
				if (i <= FEATURES) begin
					term_s1[i] <= TERM_W'(weight[i]) * TERM_W'(feat[i-1]);
				end else begin
					term_s1[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int i = 0; i < NUM_WEIGHTS/2; i++) begin
				pair_s2[i] <= PAIR_W'(term_s1[2*i]) + PAIR_W'(term_s1[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			for (int i = 0; i < 2; i++) begin
				quad_s3[i] <= QUAD_W'(pair_s2[2*i]) + QUAD_W'(pair_s2[2*i+1]);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/lcs_plan.sv
// ----------------------------------------------------------------------------
// lcs_plan
// Final sum with 32-bit saturation, then the mirrored PLAN sigmoid.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_plan #(
	parameter int FRAC_BITS = lcs_pkg::FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  lcs_pkg::plan_ctl_t                    ctl,
	input  wire signed [lcs_pkg::QUAD_W-1:0]      quad_s3 [2],
	output logic signed [lcs_pkg::SCORE_W-1:0]    score_s6,
	output logic [lcs_pkg::PROB_W-1:0]            prob_s6
);
	import lcs_pkg::*;

	localparam int FB    = 2 * FRAC_BITS;
	localparam int SHL   = (FB <= 16) ? 16 - FB : 0;
	localparam int SHR   = (FB > 16) ? FB - 16 : 0;
	localparam int MAG_W = SCORE_W + 16;
	localparam int A_W   = 19;
	localparam int Y_W   = PROB_W + 1;

	localparam logic [MAG_W-1:0] SAT_TH   = MAG_W'(327680);
	localparam logic [A_W-1:0]   MID_TH   = A_W'(155648);
	localparam logic [A_W-1:0]   ONE_TH   = A_W'(65536);
	localparam logic [Y_W-1:0]   Y_ONE    = Y_W'(65536);
	localparam logic [Y_W-1:0]   OFS_HIGH = Y_W'(55296);
	localparam logic [Y_W-1:0]   OFS_MID  = Y_W'(40960);
	localparam logic [Y_W-1:0]   OFS_LOW  = Y_W'(32768);
	localparam logic [Y_W-1:0]   Y_MAX    = Y_W'(65535);

	logic signed [SUM_W-1:0]   sum;
	logic signed [SCORE_W-1:0] score_s4;
	logic signed [SCORE_W-1:0] score_s5;
	logic [SCORE_W-1:0]        mag;
	logic [MAG_W-1:0]          a16;
	logic                      neg_s5;
	logic                      big_s5;
	logic [A_W-1:0]            a_s5;
	logic [Y_W-1:0]            y;
	logic [Y_W-1:0]            prob;

	assign sum = SUM_W'(quad_s3[0]) + SUM_W'(quad_s3[1]);

	always_ff @(posedge clk) begin
		if (ctl.adv_s4) begin
			if (!sum[SUM_W-1] && (|sum[SUM_W-2:SCORE_W-1])) begin
				score_s4 <= {1'b0, {(SCORE_W-1){1'b1}}};
			end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:SCORE_W-1])) begin
				score_s4 <= {1'b1, {(SCORE_W-1){1'b0}}};
			end else begin
				score_s4 <= sum[SCORE_W-1:0];
			end
		end
	end

	// magnitude aligned to 16 fractional bits; the most negative score still fits
	assign mag = score_s4[SCORE_W-1] ? (~score_s4 + SCORE_W'(1)) : score_s4;
	assign a16 = ({16'd0, mag} << SHL) >> SHR;

	always_ff @(posedge clk) begin
		if (ctl.adv_s5) begin
			score_s5 <= score_s4;
			neg_s5   <= score_s4[SCORE_W-1];
			big_s5   <= (a16 >= SAT_TH);
			a_s5     <= a16[A_W-1:0];
		end
	end

	always_comb begin
		priority if (big_s5) begin
			y = Y_ONE;
		end else if (a_s5 >= MID_TH) begin
			y = Y_W'(a_s5 >> 5) + OFS_HIGH;
		end else if (a_s5 >= ONE_TH) begin
			y = Y_W'(a_s5 >> 3) + OFS_MID;
		end else begin
			y = Y_W'(a_s5 >> 2) + OFS_LOW;
		end

		// mirror for negative scores, clip one to the largest code
		if (neg_s5) begin
			prob = Y_ONE - y;
		end else if (y > Y_MAX) begin
			prob = Y_MAX;
		end else begin
			prob = y;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s6) begin
			score_s6 <= score_s5;
			prob_s6  <= prob[PROB_W-1:0];
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_logistic_classifier_score.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_logistic_classifier_score
// Self-checking bench for the logistic regression score pipeline.
// ----------------------------------------------------------------------------
// A short table of directed vectors comes first. It covers zero weights after
// reset, all-extreme weights and features that drive the score into
// saturation, and scores on or beside every PLAN segment boundary for both
// signs. Random phases follow, each with its own weight set, mixing
// full-range, small and tiny features so that the score lands in every
// sigmoid segment as well as in saturation. Results are checked in order
// against table values or a local score and sigmoid predictor. Both channels
// idle in random bursts, and one long stall on the result side backs the
// pipeline up into the input.
// ----------------------------------------------------------------------------

module tb_logistic_classifier_score;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PIPE_SETTLE  = 10;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 119;
	localparam int LONG_HOLD    = 80;
	localparam int HOLD_AFTER   = 400;
	localparam int NUM_W        = lcs_pkg::NUM_WEIGHTS;
	localparam int NUM_F        = lcs_pkg::NUM_FEAT_MAX;

	typedef logic [NUM_W-1:0][lcs_pkg::WEIGHT_W-1:0] weight_set_t;
	typedef logic [NUM_F-1:0][lcs_pkg::FEAT_W-1:0]   feat_vec_t;

	typedef struct packed {
		logic                                score_valid_unused;
		logic signed [lcs_pkg::SCORE_W-1:0]  score;
		logic        [lcs_pkg::PROB_W-1:0]   prob;
	} score_pair_t;

	typedef struct packed {
		logic                                load;
		weight_set_t                         weights;
		feat_vec_t                           features;
		logic                                known;
		logic signed [lcs_pkg::SCORE_W-1:0]  score;
		logic        [lcs_pkg::PROB_W-1:0]   prob;
	} stim_row_t;

	// element 0 is the bias for weights and feature_1 for features
	localparam weight_set_t W_ZERO = '0;
	localparam weight_set_t W_MAX  = {NUM_W{16'h7FFF}};
	localparam weight_set_t W_MIN  = {NUM_W{16'h8000}};
	localparam weight_set_t W_STEP = {16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0001, 16'h0100, 16'h0000};
	localparam feat_vec_t F_ZERO = '0;
	localparam feat_vec_t F_MAX  = {NUM_F{16'h7FFF}};
	localparam feat_vec_t F_MIN  = {NUM_F{16'h8000}};

	localparam int DIRECTED_ROWS = 19;
	// with W_STEP the score is 256 * feature_1 + feature_2
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, W_ZERO, F_ZERO, 1'b1, 32'sh0000_0000, 16'h8000},
		'{1'b0, W_ZERO, F_MAX,  1'b1, 32'sh0000_0000, 16'h8000},
		'{1'b0, W_ZERO, F_MIN,  1'b1, 32'sh0000_0000, 16'h8000},
		'{1'b1, W_MIN,  F_MIN,  1'b1, 32'sh7FFF_FFFF, 16'hFFFF},
		'{1'b0, W_MIN,  F_MAX,  1'b1, 32'sh8000_0000, 16'h0000},
		'{1'b0, W_MIN,  F_ZERO, 1'b1, 32'shFF80_0000, 16'h0000},
		'{1'b1, W_MAX,  F_MAX,  1'b1, 32'sh7FFF_FFFF, 16'hFFFF},
		'{1'b0, W_MAX,  F_MIN,  1'b1, 32'sh8000_0000, 16'h0000},
		'{1'b1, W_STEP, {80'h0, 16'h00FF, 16'h00FF}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'h0100}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'hFFFF, 16'h0260}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'h0260}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'hFFFF, 16'h0500}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'h0500}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'hFF00}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0001, 16'hFDA0}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'hFB00}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0000, 16'hFFFF}, 1'b0, 32'sh0, 16'h0},
		'{1'b0, W_STEP, {80'h0, 16'h0001, 16'h0000}, 1'b0, 32'sh0, 16'h0}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [lcs_pkg::WIDX_W-1:0]         cfg_index;
	logic [lcs_pkg::WEIGHT_W-1:0]       cfg_data;

	lcs_in_if  sample_ch ();
	lcs_out_if result_ch ();

	weight_set_t   weight_bank;
	score_pair_t   pending_results [$];
	score_pair_t   oldest_result;
	int            mismatches;
	int            results_seen;
	int            cycle_count;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            hold_cnt;
	bit            long_hold_done;

	logistic_classifier_score u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always #10 clk = ~clk;

	function automatic logic signed [lcs_pkg::SCORE_W-1:0] weighted_score(input feat_vec_t f);
		logic signed [63:0] acc;
		logic signed [63:0] term;
		acc = $signed(weight_bank[0]);
		acc = acc * 256;
		for (int k = 0; k < NUM_F; k++) begin
			term = $signed(weight_bank[k + 1]);
			term = term * $signed(f[k]);
			acc  = acc + term;
		end
		if (acc > 64'sh0000_0000_7FFF_FFFF)
			acc = 64'sh0000_0000_7FFF_FFFF;
		if (acc < -64'sh0000_0000_8000_0000)
			acc = -64'sh0000_0000_8000_0000;
		return acc[31:0];
	endfunction

	function automatic logic [lcs_pkg::PROB_W-1:0] plan_probability(
			input logic signed [lcs_pkg::SCORE_W-1:0] s);
		logic signed [33:0] wide;
		logic [33:0]        mag;
		logic [33:0]        y;
		wide = s;
		mag  = (wide < 0) ? -wide : wide;
		if (mag >= 34'd327680)
			y = 34'd65536;
		else if (mag >= 34'd155648)
			y = (mag >> 5) + 34'd55296;
		else if (mag >= 34'd65536)
			y = (mag >> 3) + 34'd40960;
		else
			y = (mag >> 2) + 34'd32768;
		if (s < 0)
			y = 34'd65536 - y;
		else if (y > 34'd65535)
			y = 34'd65535;
		return y[15:0];
	endfunction

	function automatic weight_set_t draw_weights(input int mode);
		weight_set_t w;
		int          v;
		for (int i = 0; i < NUM_W; i++) begin
			case (mode)
				0: w[i] = 16'($urandom);
				1: begin
					v    = int'($urandom_range(768, 0)) - 384;
					w[i] = v[15:0];
				end
				default: begin
					v    = int'($urandom_range(512, 0)) - 256;
					w[i] = ($urandom_range(1, 0) == 0) ? 16'h0000 : v[15:0];
				end
			endcase
		end
		return w;
	endfunction

	function automatic feat_vec_t draw_features();
		feat_vec_t f;
		int        mode;
		int        v;
		mode = $urandom_range(99, 0);
		for (int k = 0; k < NUM_F; k++) begin
			if (mode < 25) begin
				f[k] = 16'($urandom);
			end else if (mode < 65) begin
				v    = int'($urandom_range(1024, 0)) - 512;
				f[k] = v[15:0];
			end else if (mode < 85) begin
				v    = int'($urandom_range(128, 0)) - 64;
				f[k] = v[15:0];
			end else begin
				case ($urandom_range(3, 0))
					0: f[k] = 16'h7FFF;
					1: f[k] = 16'h8000;
					2: f[k] = 16'h0000;
					default: f[k] = 16'($urandom);
				endcase
			end
		end
		return f;
	endfunction

	// offer one vector and hold it until the transaction completes
	task automatic push_vector(input feat_vec_t f, input bit given,
			input score_pair_t given_result);
		score_pair_t predicted;
		sample_ch.valid     <= 1'b1;
		sample_ch.feature_1 <= f[0];
		sample_ch.feature_2 <= f[1];
		sample_ch.feature_3 <= f[2];
		sample_ch.feature_4 <= f[3];
		sample_ch.feature_5 <= f[4];
		sample_ch.feature_6 <= f[5];
		sample_ch.feature_7 <= f[6];
		do @(posedge clk); while (!sample_ch.ready);
		if (given) begin
			pending_results.push_back(given_result);
		end else begin
			predicted.score_valid_unused = 1'b0;
			predicted.score = weighted_score(f);
			predicted.prob  = plan_probability(predicted.score);
			pending_results.push_back(predicted);
		end
		if (int'($urandom_range(99, 0)) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic load_weights(input weight_set_t w);
		for (int i = 0; i < NUM_W; i++) begin
			cfg_we         <= 1'b1;
			cfg_index      <= lcs_pkg::WIDX_W'(i);
			cfg_data       <= w[i];
			weight_bank[i]  = w[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off once traffic is flowing
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt        <= hold_cnt - 1;
			result_ch.ready <= (hold_cnt == 1);
		end else if (!long_hold_done && results_seen >= HOLD_AFTER && sample_ch.valid) begin
			long_hold_done  <= 1'b1;
			hold_cnt        <= LONG_HOLD;
			result_ch.ready <= 1'b0;
		end else if (int'($urandom_range(99, 0)) < rx_idle_pct) begin
			hold_cnt        <= $urandom_range(8, 1);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got score %0d probability %0d",
					$time, $signed(result_ch.score), result_ch.probability);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (result_ch.score !== oldest_result.score) begin
					$display("%0t: score mismatch, expected %0d, got %0d", $time,
						$signed(oldest_result.score), $signed(result_ch.score));
					mismatches++;
				end
				if (result_ch.probability !== oldest_result.prob) begin
					$display("%0t: probability mismatch, expected %0d, got %0d", $time,
						oldest_result.prob, result_ch.probability);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		score_pair_t known_result;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.feature_1 = '0;
		sample_ch.feature_2 = '0;
		sample_ch.feature_3 = '0;
		sample_ch.feature_4 = '0;
		sample_ch.feature_5 = '0;
		sample_ch.feature_6 = '0;
		sample_ch.feature_7 = '0;
		result_ch.ready     = 1'b0;
		weight_bank         = W_ZERO;
		mismatches          = 0;
		results_seen        = 0;
		cycle_count         = 0;
		hold_cnt            = 0;
		long_hold_done      = 1'b0;
		tx_idle_pct         = 30;
		rx_idle_pct         = 30;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].load) begin
				drain_pipeline();
				load_weights(DIRECTED[r].weights);
			end
			known_result.score_valid_unused = 1'b0;
			known_result.score = DIRECTED[r].score;
			known_result.prob  = DIRECTED[r].prob;
			push_vector(DIRECTED[r].features, DIRECTED[r].known, known_result);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_pipeline();
			load_weights(draw_weights(p % 3));
			// quiet channels for the closing phases
			if (p >= PHASES - 2) begin
				tx_idle_pct  = 0;
				rx_idle_pct <= 0;
			end else begin
				tx_idle_pct  = 25 * $urandom_range(2, 0);
				rx_idle_pct <= 25 * $urandom_range(2, 0);
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_vector(draw_features(), 1'b0, known_result);
		end

		drain_pipeline();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
